FILE: hw/rtl/fbc_pkg.sv
package fbc_pkg;

    // Field widths and counts
    localparam int COEF_WIDTH      = 16;
    localparam int COORD_WIDTH     = 20;
    localparam int NUM_PLANES      = 6;
    localparam int NUM_AXES        = 3;
    localparam int NUM_COLS        = 4;
    localparam int FIELD_WIDTH     = 16;
    localparam int CFG_WIDTH       = 64;
    localparam int CFG_ADDR_WIDTH  = 2;
    localparam int DIST_SHIFT      = 8;

    // Arithmetic widths: plane coefficient is a sum or difference of two coefficients
    localparam int PLANE_WIDTH     = COEF_WIDTH + 1;
    localparam int PROD_WIDTH      = PLANE_WIDTH + COORD_WIDTH;
    localparam int SUM_WIDTH       = PROD_WIDTH + 2;

    // Result queue between front and back
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

    // Register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MATRIX_COL0 = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MATRIX_COL1 = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MATRIX_COL2 = 2'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MATRIX_COL3 = 2'd3;

    // Containment codes
    localparam logic [1:0] CONT_OUTSIDE   = 2'd0;
    localparam logic [1:0] CONT_INTERSECT = 2'd1;
    localparam logic [1:0] CONT_INSIDE    = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PLANE_WIDTH-1:0] plane_coef_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;

    // Per-plane test outcomes of one box
    typedef struct packed {
        logic [NUM_PLANES-1:0] far_neg;
        logic [NUM_PLANES-1:0] near_neg;
    } plane_flags_t;

    // Row 3 plus (even plane) or minus (odd plane) row p/2 of one column
    function automatic plane_coef_t plane_term(input logic [CFG_WIDTH-1:0] col,
                                               input int unsigned plane);
        logic signed [COEF_WIDTH-1:0] r3;
        logic signed [COEF_WIDTH-1:0] rk;
        logic [1:0]                   row;
        row = 2'(plane >> 1);
        r3  = col[3*FIELD_WIDTH +: COEF_WIDTH];
        rk  = col[row*FIELD_WIDTH +: COEF_WIDTH];
        if (plane[0])
            return plane_coef_t'(r3) - plane_coef_t'(rk);
        else
            return plane_coef_t'(r3) + plane_coef_t'(rk);
    endfunction

endpackage

FILE: hw/rtl/fbc_if.sv
interface fbc_box_if
    import fbc_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    output ready);
endinterface

interface fbc_result_if
    import fbc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] containment;
    logic       visible;

    modport source (output valid, containment, visible, input ready);
    modport sink   (input valid, containment, visible, output ready);
endinterface

interface fbc_cfg_if
    import fbc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_ADDR_WIDTH-1:0] addr;
    logic [CFG_WIDTH-1:0]      data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

FILE: hw/rtl/fbc_front.sv
module fbc_front
    import fbc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    fbc_box_if.sink       box,
    fbc_cfg_if.sink       cfg,
    input  logic          queue_full,
    output logic          push_valid,
    output plane_flags_t  push_flags
);

    logic [CFG_WIDTH-1:0] matrix_reg [NUM_COLS];
    plane_coef_t          coef [NUM_PLANES][NUM_COLS];

    logic   advance;
    logic   s1_valid_reg;
    coord_t lo_reg [NUM_AXES];
    coord_t hi_reg [NUM_AXES];

    logic   s2_valid_reg;
    prod_t  far_prod [NUM_PLANES][NUM_AXES];
    prod_t  near_prod [NUM_PLANES][NUM_AXES];
    sum_t   dist_term [NUM_PLANES];
    prod_t  far_prod_reg [NUM_PLANES][NUM_AXES];
    prod_t  near_prod_reg [NUM_PLANES][NUM_AXES];
    sum_t   dist_reg [NUM_PLANES];

    // Accept matrix columns at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                matrix_reg[c] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                REG_MATRIX_COL0: matrix_reg[0] <= cfg.data;
                REG_MATRIX_COL1: matrix_reg[1] <= cfg.data;
                REG_MATRIX_COL2: matrix_reg[2] <= cfg.data;
                REG_MATRIX_COL3: matrix_reg[3] <= cfg.data;
                default:         matrix_reg[0] <= matrix_reg[0];
            endcase
        end
    end

    // Form plane coefficients from the matrix rows
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                coef[p][c] = plane_term(matrix_reg[c], p);
            end
        end
    end

    // Stall the whole front only when the last stage cannot push
    assign advance   = !s2_valid_reg || !queue_full;
    assign box.ready = advance;

    // Stage 1: capture box bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= box.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && box.valid)
        begin
            lo_reg[0] <= box.min_x;
            lo_reg[1] <= box.min_y;
            lo_reg[2] <= box.min_z;
            hi_reg[0] <= box.max_x;
            hi_reg[1] <= box.max_y;
            hi_reg[2] <= box.max_z;
        end
    end

    // Stage 2: pick far and near corners by normal sign, multiply
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            dist_term[p] = sum_t'(coef[p][3]) <<< DIST_SHIFT;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (coef[p][i][PLANE_WIDTH-1])
                begin
                    far_prod[p][i]  = prod_t'(coef[p][i]) * prod_t'(lo_reg[i]);
                    near_prod[p][i] = prod_t'(coef[p][i]) * prod_t'(hi_reg[i]);
                end
                else
                begin
                    far_prod[p][i]  = prod_t'(coef[p][i]) * prod_t'(hi_reg[i]);
                    near_prod[p][i] = prod_t'(coef[p][i]) * prod_t'(lo_reg[i]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                dist_reg[p] <= dist_term[p];
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    far_prod_reg[p][i]  <= far_prod[p][i];
                    near_prod_reg[p][i] <= near_prod[p][i];
                end
            end
        end
    end

    // Stage 3: sum terms and take the sign of each test
    always_comb
    begin
        sum_t far_sum;
        sum_t near_sum;
        push_flags = '0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            far_sum  = dist_reg[p];
            near_sum = dist_reg[p];
            for (int i = 0; i < NUM_AXES; i++)
            begin
                far_sum  = far_sum + sum_t'(far_prod_reg[p][i]);
                near_sum = near_sum + sum_t'(near_prod_reg[p][i]);
            end
            push_flags.far_neg[p]  = far_sum[SUM_WIDTH-1];
            push_flags.near_neg[p] = near_sum[SUM_WIDTH-1];
        end
    end

    assign push_valid = s2_valid_reg;

endmodule

FILE: hw/rtl/fbc_queue.sv
module fbc_queue
    import fbc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  plane_flags_t  push_flags,
    output logic          full,
    output logic          pop_valid,
    input  logic          pop_ready,
    output plane_flags_t  pop_flags
);

    plane_flags_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_WIDTH:0]   count_reg;
    logic [QUEUE_PTR_WIDTH:0]   count_next;
    logic                       push_fire;
    logic                       pop_fire;

    assign full      = (count_reg == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_flags = entry_reg[rd_ptr_reg];
    assign push_fire = push_valid && !full;
    assign pop_fire  = pop_valid && pop_ready;

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
            count_next = count_reg + 1'b1;
        else if (pop_fire && !push_fire)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Store pushed entry
    always_ff @(posedge clk)
    begin
        if (push_fire)
            entry_reg[wr_ptr_reg] <= push_flags;
    end

endmodule

FILE: hw/rtl/fbc_back.sv
module fbc_back
    import fbc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  plane_flags_t  pop_flags,
    fbc_result_if.source  result
);

    logic       out_valid_reg;
    logic [1:0] containment_reg;
    logic       visible_reg;
    logic       load;
    logic [1:0] containment;

    // Reduce plane flags: any far corner behind a plane culls the box
    always_comb
    begin
        priority if (|pop_flags.far_neg)
            containment = CONT_OUTSIDE;
        else if (|pop_flags.near_neg)
            containment = CONT_INTERSECT;
        else
            containment = CONT_INSIDE;
    end

    // Refill the output register when empty or taken
    assign load      = !out_valid_reg || result.ready;
    assign pop_ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && pop_valid)
        begin
            containment_reg <= containment;
            visible_reg     <= (containment != CONT_OUTSIDE);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.containment = containment_reg;
    assign result.visible     = visible_reg;

endmodule

FILE: hw/rtl/frustum_box_classifier_core.sv
// Frustum box classifier: tests each axis-aligned box (signed Q12.8 bounds)
// against the six clip planes of the view-projection matrix written through
// the configuration channel (register i holds matrix column i, rows 0..3 as
// signed Q4.12 in 16-bit fields; all zero after reset, which makes every box
// fully inside). One box is accepted per clock unless the front stalls on a
// full queue, and one result returns per box in order: containment 0 outside,
// 1 intersecting, 2 fully inside, and the visible bit. A box passes four
// registers: bound capture at its accept edge, the 36 parallel products of
// coefficients by coordinates, a four-entry result queue fed by the
// per-plane sums and sign tests, and the output register.
// The queue lets the output stall without stalling the input at once; the
// input channel stops only when the queue is full. Write the matrix only
// while no box is in flight.
module frustum_box_classifier_core
    import fbc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    fbc_box_if.sink       box,
    fbc_result_if.source  result,
    fbc_cfg_if.sink       cfg
);

    logic         push_valid;
    plane_flags_t push_flags;
    logic         queue_full;
    logic         pop_valid;
    logic         pop_ready;
    plane_flags_t pop_flags;

    fbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .box        (box),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_flags (push_flags)
    );

    fbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_flags (push_flags),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_flags  (pop_flags)
    );

    fbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_flags (pop_flags),
        .result    (result)
    );

endmodule
